>>> hdl/ffat_pkg.sv
package ffat_pkg;

  localparam int NUM_ROWS   = 4;
  localparam int ROW_DEPTH  = 1024;
  localparam int TABLE_SIZE = 1024;
  localparam int ROW_W      = $clog2(ROW_DEPTH);
  localparam int BKT_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [9:0]         row_index_0;
    logic [9:0]         row_index_1;
    logic [9:0]         row_index_2;
    logic [9:0]         row_index_3;
    logic [9:0]         bucket_index;
    logic signed [31:0] value;
  } ffat_in_t;

  typedef struct packed {
    logic signed [31:0] average;
    logic               found;
  } ffat_out_t;

  typedef struct packed {
    logic                               is_query;
    logic [NUM_ROWS-1:0][ROW_W-1:0]     row_addr;
    logic [BKT_W-1:0]                   home;
    logic signed [31:0]                 value;
  } ffat_cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] x);
    sat_inc16 = (x == {CNT_W{1'b1}}) ? x : x + CNT_W'(1);
  endfunction

endpackage

>>> hdl/ffat_divider.sv
module ffat_divider import ffat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem, quo[63]};
  assign ge = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 6'd0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? 32'(sh - {1'b0, dvs}) : sh[31:0];
      quo <= {quo[62:0], ge};
    end
  end

endmodule

>>> hdl/ffat_engine.sv
module ffat_engine import ffat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  output logic      clearing,
  input  logic      empty,
  input  ffat_cmd_t q_data,
  output logic      pop,
  output ffat_out_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_stall
);

  localparam int CLR_W = (ROW_W > BKT_W) ? ROW_W : BKT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FRD  = 4'd1;
  localparam logic [3:0] S_BW   = 4'd2;
  localparam logic [3:0] S_B1   = 4'd3;
  localparam logic [3:0] S_BW2  = 4'd4;
  localparam logic [3:0] S_B2   = 4'd5;
  localparam logic [3:0] S_FWR  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]        state;
  ffat_cmd_t         cmd_r;
  logic [CNT_W-1:0]  fcnt;
  logic [BKT_W-1:0]  baddr;
  logic [CNT_W:0]    code;
  logic              neg;
  ffat_out_t         res;
  logic [CLR_W-1:0]  clr;

  logic [NUM_ROWS-1:0][CNT_W-1:0] fdata;
  logic [NUM_ROWS-1:0][ROW_W-1:0] fra;
  logic [NUM_ROWS-1:0][ROW_W-1:0] fwa;
  logic [NUM_ROWS-1:0]            fwe;
  logic [CNT_W-1:0]               fwd;

  logic [CNT_W-1:0]   s_rd;
  logic [31:0]        c_rd;
  logic signed [63:0] r_rd;
  logic               swe;
  logic               rwe;
  logic [BKT_W-1:0]   bwa;
  logic [CNT_W-1:0]   swd;

  logic [CNT_W-1:0]  fcnt_c;
  logic              any_zero;
  logic              new_flow;
  logic [CNT_W-1:0]  s_inc;
  logic [31:0]       c_inc;
  logic [64:0]       s65;
  logic [63:0]       sum_new;
  logic [BKT_W-1:0]  pos_exist;
  logic [BKT_W-1:0]  pos_probe;
  logic [CNT_W-1:0]  code_sat;
  logic              div_start;
  logic              div_done;
  logic [63:0]       div_num;
  logic [63:0]       quo;
  logic signed [31:0] avg;

  assign pop = (state == S_IDLE) && !empty && !clearing;

  always_comb begin
    fcnt_c   = '0;
    any_zero = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (fdata[r] == '0) any_zero = 1'b1;
      if (fdata[r] > fcnt_c) fcnt_c = fdata[r];
    end
    if (any_zero) fcnt_c = '0;
  end

  assign new_flow  = !cmd_r.is_query && (fcnt <= CNT_W'(1));
  assign s_inc     = sat_inc16(s_rd);
  assign c_inc     = (c_rd == 32'hFFFF_FFFF) ? c_rd : c_rd + 32'd1;
  assign s65       = {r_rd[63], r_rd} + {{33{cmd_r.value[31]}}, cmd_r.value};
  assign sum_new   = (s65[64] != s65[63]) ?
                     (s65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) :
                     s65[63:0];
  assign pos_exist = cmd_r.home + fcnt_c[BKT_W-1:0] - BKT_W'(2);
  assign pos_probe = cmd_r.home + s_inc[BKT_W-1:0] - BKT_W'(1);
  assign code_sat  = code[CNT_W] ? {CNT_W{1'b1}} : code[CNT_W-1:0];
  assign div_start = (state == S_B1) && cmd_r.is_query && (c_rd != 32'd0);
  assign div_num   = r_rd[63] ? 64'(-r_rd) : 64'(r_rd);

  always_comb begin
    if (neg) begin
      avg = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-quo[31:0]);
    end else begin
      avg = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  ffat_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (c_rd),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    fwe = '0;
    fwd = '0;
    swe = 1'b0;
    rwe = 1'b0;
    bwa = baddr;
    swd = s_inc;
    for (int r = 0; r < NUM_ROWS; r++) begin
      fra[r] = (state == S_IDLE) ? q_data.row_addr[r] : cmd_r.row_addr[r];
      fwa[r] = cmd_r.row_addr[r];
    end
    if (clearing) begin
      fwe = '1;
      for (int r = 0; r < NUM_ROWS; r++) fwa[r] = clr[ROW_W-1:0];
      swe = 1'b1;
      rwe = 1'b1;
      bwa = clr[BKT_W-1:0];
      swd = '0;
    end else begin
      unique case (state)
        S_B1: begin
          if (new_flow) begin
            swe = 1'b1;
            rwe = (s_inc == CNT_W'(1));
          end else if (!cmd_r.is_query) begin
            rwe = 1'b1;
            swe = (c_inc < {16'd0, s_rd});
            swd = '0;
          end
        end
        S_B2: begin
          swe = 1'b1;
          rwe = (s_inc == CNT_W'(1));
        end
        S_FWR: begin
          fwd = code_sat;
          for (int r = 0; r < NUM_ROWS; r++) begin
            fwe[r] = (fdata[r] == '0) || (fdata[r] == CNT_W'(1)) || (fdata[r] > code_sat);
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_bank
    logic [CNT_W-1:0] bank [ROW_DEPTH];
    always_ff @(posedge clk) begin
      if (fwe[r]) bank[fwa[r]] <= fwd;
      fdata[r] <= bank[fra[r]];
    end
  end

  logic [CNT_W-1:0]   smem [TABLE_SIZE];
  logic [31:0]        cmem [TABLE_SIZE];
  logic signed [63:0] rmem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (swe) smem[bwa] <= swd;
    if (rwe) begin
      cmem[bwa] <= clearing ? 32'd0 : c_inc;
      rmem[bwa] <= clearing ? 64'sd0 : sum_new;
    end
    s_rd <= smem[baddr];
    c_rd <= cmem[baddr];
    r_rd <= rmem[baddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr <= clr + CLR_W'(1);
        if (clr == {CLR_W{1'b1}}) clearing <= 1'b0;
      end
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (pop) state <= S_FRD;
        S_FRD: begin
          if (cmd_r.is_query && fcnt_c <= CNT_W'(1)) state <= S_OUT;
          else state <= S_BW;
        end
        S_BW: state <= S_B1;
        S_B1: begin
          if (new_flow) begin
            if (s_inc == CNT_W'(1)) state <= S_FWR;
            else state <= S_BW2;
          end else if (!cmd_r.is_query) begin
            state <= (c_inc < {16'd0, s_rd}) ? S_FWR : S_OUT;
          end else begin
            state <= (c_rd != 32'd0) ? S_DIV : S_OUT;
          end
        end
        S_BW2: state <= S_B2;
        S_B2: state <= (s_inc == CNT_W'(1)) ? S_FWR : S_OUT;
        S_FWR: state <= S_OUT;
        S_DIV: if (div_done) state <= S_OUT;
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_data;
    if (state == S_FRD) begin
      fcnt  <= fcnt_c;
      res   <= '0;
      baddr <= (!cmd_r.is_query && fcnt_c <= CNT_W'(1)) ? cmd_r.home : pos_exist;
    end
    if (state == S_B1) begin
      if (new_flow) begin
        code <= {1'b0, s_inc} + (CNT_W+1)'(1);
        if (s_inc != CNT_W'(1)) baddr <= pos_probe;
      end else begin
        code <= (CNT_W+1)'(1);
      end
      neg <= r_rd[63];
    end
    if (state == S_DIV && div_done) begin
      res.average <= avg;
      res.found   <= 1'b1;
    end
    if (state == S_OUT && (!rsp_valid || !rsp_stall)) rsp <= res;
  end

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == S_IDLE) else $error("clearing pass overlaps item work");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_DIV || state == S_OUT) else $error("divide left early");

  a_fwr_insert: assert property (@(posedge clk) disable iff (rst)
    state == S_FWR |-> !cmd_r.is_query) else $error("filter write on query");

endmodule

>>> hdl/ffat_queue.sv
module ffat_queue import ffat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ffat_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output ffat_cmd_t pop_data,
  output logic      empty
);

  ffat_cmd_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

>>> hdl/ffat_front.sv
module ffat_front import ffat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      clearing,
  input  ffat_in_t  cmd,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output logic      push,
  output ffat_cmd_t push_data,
  input  logic      full
);

  logic      held;
  ffat_cmd_t slot;
  logic      take;

  assign push      = held && !full;
  assign push_data = slot;
  assign cmd_stall = clearing || (held && full);
  assign take      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot.is_query    <= cmd.op == OP_QUERY;
      slot.row_addr[0] <= cmd.row_index_0[ROW_W-1:0];
      slot.row_addr[1] <= cmd.row_index_1[ROW_W-1:0];
      slot.row_addr[2] <= cmd.row_index_2[ROW_W-1:0];
      slot.row_addr[3] <= cmd.row_index_3[ROW_W-1:0];
      slot.home        <= cmd.bucket_index[BKT_W-1:0];
      slot.value       <= cmd.value;
    end
  end

endmodule

>>> hdl/flow_filter_average_tracker.sv
// Per-flow average tracker: four filter rows of 1024 16-bit counters in front of a
// 1024-bucket table. After reset the block runs a clearing pass over every entry and
// holds cmd_stall high until it ends. Items pass a one-entry input register and a
// two-entry queue and are executed one at a time: an insert does a filter read, one
// or two dependent bucket read-modify-writes and, where needed, a filter write-back;
// a query of a tracked flow with records waits for the 64-step bit-serial divider
// that forms records / count, and a query of an unknown flow skips the bucket read.
// Every item gives exactly one result.
module flow_filter_average_tracker import ffat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ffat_in_t  cmd,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output ffat_out_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_stall
);

  logic      clearing;
  logic      push;
  ffat_cmd_t push_data;
  logic      full;
  logic      pop;
  ffat_cmd_t pop_data;
  logic      empty;

  ffat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ffat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ffat_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .empty     (empty),
    .q_data    (pop_data),
    .pop       (pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

>>> tb/tb_flow_filter_average_tracker.sv
module tb_flow_filter_average_tracker;
  import ffat_pkg::*;

  localparam int FILT_DEPTH = 4096;
  localparam int IDLE_LIMIT = 6000;
  localparam int NUM_FLOWS  = 48;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  ffat_in_t  cmd = '0;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  ffat_out_t rsp;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;

  flow_filter_average_tracker i_dut (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  logic [15:0] filt_cnt [FILT_DEPTH];
  logic [15:0] sentinel [TABLE_SIZE];
  logic [31:0] flow_cnt [TABLE_SIZE];
  longint      rec_sum  [TABLE_SIZE];

  ffat_in_t  pending_items[$];
  bit        drain_first[$];
  ffat_out_t expected_rsp[$];
  ffat_in_t  flows[NUM_FLOWS];

  bit  quiet = 1'b0;
  bit  stim_done = 1'b0;
  bit  cmd_taken = 1'b0;
  int  cmd_gap = 0;
  int  rsp_gap = 0;
  int  idle_cycles = 0;
  int  errors = 0;

  always #2 clk = ~clk;

  function automatic void bump_sentinel(int unsigned b);
    if (sentinel[b] != 16'hFFFF) sentinel[b] = sentinel[b] + 16'd1;
  endfunction

  function automatic void add_record(int unsigned b, logic signed [31:0] value);
    longint v;
    longint s;
    v = longint'(value);
    s = rec_sum[b];
    if (flow_cnt[b] != 32'hFFFF_FFFF) flow_cnt[b] = flow_cnt[b] + 32'd1;
    if (v > 0 && s > 64'sh7FFF_FFFF_FFFF_FFFF - v) s = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (v < 0 && s < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - v) s = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    else s = s + v;
    rec_sum[b] = s;
  endfunction

  function automatic ffat_out_t track_flow(ffat_in_t c);
    int unsigned addr[4];
    int unsigned fc, code, home, pos, stp;
    bit          any_zero;
    longint      avg;
    ffat_out_t   r;
    addr[0] = 0 * ROW_DEPTH + c.row_index_0;
    addr[1] = 1 * ROW_DEPTH + c.row_index_1;
    addr[2] = 2 * ROW_DEPTH + c.row_index_2;
    addr[3] = 3 * ROW_DEPTH + c.row_index_3;
    fc = 0;
    any_zero = 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (filt_cnt[addr[i]] == 0) any_zero = 1'b1;
      if (filt_cnt[addr[i]] > fc) fc = filt_cnt[addr[i]];
    end
    if (any_zero) fc = 0;
    home = c.bucket_index;
    r = '0;
    if (c.op == OP_INSERT) begin
      code = 0;
      if (fc <= 1) begin
        pos = home;
        bump_sentinel(home);
        code = sentinel[home] + 1;
        if (sentinel[home] != 1) begin
          stp = sentinel[home] - 1;
          pos = (home + stp) % TABLE_SIZE;
          bump_sentinel(pos);
          if (sentinel[pos] != 1) code = 0;
        end
        if (code != 0) add_record(pos, c.value);
      end else begin
        pos = (home + fc - 2) % TABLE_SIZE;
        add_record(pos, c.value);
        if (flow_cnt[pos] < {16'd0, sentinel[pos]}) begin
          sentinel[pos] = '0;
          code = 1;
        end
      end
      if (code > 65535) code = 65535;
      if (code != 0) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          if (filt_cnt[addr[i]] <= 1 || filt_cnt[addr[i]] > code)
            filt_cnt[addr[i]] = code[15:0];
        end
      end
    end else if (fc > 1) begin
      pos = (home + fc - 2) % TABLE_SIZE;
      if (flow_cnt[pos] != 0) begin
        avg = rec_sum[pos] / longint'({32'd0, flow_cnt[pos]});
        if (avg > 64'sd2147483647) avg = 64'sd2147483647;
        if (avg < -64'sd2147483648) avg = -64'sd2147483648;
        r.average = avg[31:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(logic op, ffat_in_t f, logic [31:0] value, bit drain);
    ffat_in_t c;
    c = f;
    c.op = op;
    c.value = value;
    pending_items.push_back(c);
    drain_first.push_back(drain);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_taken) begin
        // hold stalled item
      end else if (cmd_gap > 0) begin
        cmd_gap <= cmd_gap - 1;
        cmd_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        cmd_valid <= 1'b0;
      end else if (drain_first[0] && expected_rsp.size() != 0) begin
        cmd_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        cmd_gap <= $urandom_range(0, 4);
        cmd_valid <= 1'b0;
      end else begin
        cmd <= pending_items.pop_front();
        void'(drain_first.pop_front());
        cmd_valid <= 1'b1;
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_gap <= $urandom_range(0, 4);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ffat_out_t want;
    cmd_taken <= cmd_valid && !cmd_stall && !rst;
    if (!rst && cmd_valid && !cmd_stall) expected_rsp.push_back(track_flow(cmd));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result: average %0d found %0b", rsp.average, rsp.found);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.average !== want.average) begin
          $error("average: expected %0d, actual %0d", want.average, rsp.average);
          errors++;
        end
        if (rsp.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, rsp.found);
          errors++;
        end
      end
    end
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_flow_filter_average_tracker: FAIL");
      $finish;
    end
  end

  initial begin
    ffat_in_t f;
    for (int i = 0; i < FILT_DEPTH; i++) filt_cnt[i] = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      sentinel[i] = '0;
      flow_cnt[i] = '0;
      rec_sum[i] = 0;
    end
    for (int i = 0; i < NUM_FLOWS; i++) begin
      flows[i] = '0;
      flows[i].row_index_0 = 10'($urandom);
      flows[i].row_index_1 = 10'($urandom);
      flows[i].row_index_2 = 10'($urandom);
      flows[i].row_index_3 = 10'($urandom);
      // share home buckets among some flows to force probing
      flows[i].bucket_index = (i < 8) ? 10'd1023 : 10'($urandom);
    end
    flows[0].row_index_0 = '1;
    flows[0].row_index_1 = '1;
    flows[0].row_index_2 = '1;
    flows[0].row_index_3 = '1;
    flows[1].row_index_0 = '0;
    flows[1].row_index_1 = '0;
    flows[1].row_index_2 = '0;
    flows[1].row_index_3 = '0;
    flows[1].bucket_index = '0;

    push_item(OP_QUERY, flows[0], 32'h0, 1'b0);
    push_item(OP_INSERT, flows[0], 32'h7FFF_FFFF, 1'b0);
    push_item(OP_INSERT, flows[0], 32'h7FFF_FFFF, 1'b0);
    push_item(OP_QUERY, flows[0], 32'hFFFF_FFFF, 1'b0);
    push_item(OP_INSERT, flows[1], 32'h8000_0000, 1'b0);
    push_item(OP_INSERT, flows[1], 32'hFFFF_FFFF, 1'b0);
    push_item(OP_QUERY, flows[1], 32'h0, 1'b0);
    for (int i = 2; i < 8; i++) begin
      push_item(OP_INSERT, flows[i], -32'sd7, 1'b0);
      push_item(OP_INSERT, flows[i], 32'd3, 1'b0);
    end
    for (int i = 0; i < 8; i++) push_item(OP_QUERY, flows[i], 32'h0, 1'b0);

    for (int n = 0; n < 800; n++) begin
      if ($urandom_range(0, 6) == 0) begin
        f = ffat_in_t'({$urandom, $urandom});
        push_item(f.op, f, rand_value(), n == 300 || n == 600);
      end else begin
        f = flows[$urandom_range(0, NUM_FLOWS - 1)];
        push_item($urandom_range(0, 9) < 6 ? OP_INSERT : OP_QUERY, f, rand_value(),
                  n == 300 || n == 600);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() < 120);
    quiet = 1'b1;
    wait (pending_items.size() == 0);
    do @(negedge clk); while (cmd_valid || expected_rsp.size() != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_flow_filter_average_tracker: PASS");
    end else begin
      $display("tb_flow_filter_average_tracker: FAIL");
    end
    $finish;
  end

endmodule
